[sv/cbem_pkg.sv]
// Shared types and constants for the color border edge map unit.
// No dependencies; cbem_seq, cbem_edge and the top module import it.
package cbem_pkg;

    localparam int RGB_W      = 24;
    localparam int ENTRY_W    = 2 * RGB_W;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_WID_W  = 12;
    localparam int CFG_HGT_W  = 16;
    localparam int ROW_W      = CFG_HGT_W + 1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef logic [RGB_W-1:0]   t_pixel;
    typedef logic [ENTRY_W-1:0] t_entry;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_pixel pixel_rgb;
        logic   flush;
    } t_in_beat;

    typedef struct packed {
        logic is_edge;
        logic last;
    } t_out_beat;

    typedef struct packed {
        logic emit;
        logic last;
        logic interior;
    } t_item_flags;

endpackage

[sv/cbem_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/cbem_seq.sv]
// Input sequencer: frame geometry registers, raster position counters,
// item classification and the first pipeline stage. Depends on cbem_pkg.
module cbem_seq #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  cbem_pkg::t_cfg_reg           i_cfg_index,
    input  logic [cbem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    input  cbem_pkg::t_in_beat           i_in_data,
    output logic                         o_in_stall,
    input  logic                         i_s1_adv,
    output logic                         o_s1_valid,
    output cbem_pkg::t_pixel             o_s1_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0] o_s1_col,
    output cbem_pkg::t_item_flags        o_s1_flags,
    output logic                         o_ram_re,
    output logic [$clog2(MAX_WIDTH)-1:0] o_ram_raddr
);
    import cbem_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int CMPW = (WW > CFG_WID_W) ? WW : CFG_WID_W;
    localparam int W_RESET_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WW-1:0]        r_w;
    logic [WW-1:0]        n_w;
    logic [CFG_HGT_W-1:0] r_h;
    logic [CFG_HGT_W-1:0] n_h;
    logic [CW-1:0]        r_col;
    logic [CW-1:0]        n_col;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     n_row;
    logic                 r_s1_v;
    t_pixel               r_s1_pixel;
    logic [CW-1:0]        r_s1_col;
    t_item_flags          r_s1_flags;

    logic [CMPW-1:0]  cfg_w_ext;
    logic [ROW_W-1:0] h_ext;
    logic             drain;
    logic             skip;
    logic             accept;
    logic             load;
    logic             col_wrap;
    t_item_flags      flags;

    assign cfg_w_ext = CMPW'(i_cfg_data[CFG_WID_W-1:0]);
    assign h_ext     = ROW_W'(r_h);

    assign o_in_stall = r_s1_v && !i_s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign drain      = r_row >= h_ext;
    assign skip       = !drain && i_in_data.flush;
    assign load       = accept && !skip;
    assign col_wrap   = (WW'(r_col) + WW'(1)) >= r_w;

    assign flags.emit     = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
    assign flags.last     = (r_row == (h_ext + ROW_W'(1))) && (r_col == '0);
    assign flags.interior = (r_row >= ROW_W'(2)) && !drain && (r_col >= CW'(2));

    always_comb begin
        n_w = r_w;
        n_h = r_h;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    if (cfg_w_ext == '0) begin
                        n_w = WW'(1);
                    end else if (cfg_w_ext > CMPW'(MAX_WIDTH)) begin
                        n_w = WW'(MAX_WIDTH);
                    end else begin
                        n_w = WW'(cfg_w_ext);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (i_cfg_data[CFG_HGT_W-1:0] == '0) begin
                        n_h = CFG_HGT_W'(1);
                    end else begin
                        n_h = i_cfg_data[CFG_HGT_W-1:0];
                    end
                end
                default: begin
                    n_w = r_w;
                end
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (load && flags.last) begin
            n_col = '0;
            n_row = '0;
        end else if (load) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end else begin
            n_col = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WW'(W_RESET_EFF);
            r_h    <= CFG_HGT_W'(HEIGHT_RESET);
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_w   <= n_w;
            r_h   <= n_h;
            r_col <= n_col;
            r_row <= n_row;
            if (load) begin
                r_s1_v <= 1'b1;
            end else if (i_s1_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_pixel <= drain ? '0 : i_in_data.pixel_rgb;
            r_s1_col   <= r_col;
            r_s1_flags <= flags;
        end
    end

    assign o_s1_valid  = r_s1_v;
    assign o_s1_pixel  = r_s1_pixel;
    assign o_s1_col    = r_s1_col;
    assign o_s1_flags  = r_s1_flags;
    assign o_ram_re    = load;
    assign o_ram_raddr = r_col;

endmodule

[sv/cbem_edge.sv]
// Edge stage: line store write-back with forwarding, neighbor window,
// four-way color compare and the output register. Depends on cbem_pkg.
module cbem_edge #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s1_valid,
    input  cbem_pkg::t_pixel             i_s1_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_s1_col,
    input  cbem_pkg::t_item_flags        i_s1_flags,
    output logic                         o_s1_adv,
    input  logic                         i_ram_re,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_ram_raddr,
    input  cbem_pkg::t_entry             i_ram_rdata,
    output logic                         o_ram_we,
    output logic [$clog2(MAX_WIDTH)-1:0] o_ram_waddr,
    output cbem_pkg::t_entry             o_ram_wdata,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output cbem_pkg::t_out_beat          o_out_data
);
    import cbem_pkg::*;

    logic      r_fwd;
    t_entry    r_fwd_data;
    t_pixel    r_w0_top;
    t_pixel    r_w0_mid;
    t_pixel    r_w0_bot;
    t_pixel    r_w1_mid;
    logic      r_out_v;
    t_out_beat r_out_data;

    t_entry col_entry;
    t_pixel row_m1;
    t_pixel row_m2;
    logic   step;
    logic   is_edge;

    assign col_entry = r_fwd ? r_fwd_data : i_ram_rdata;
    assign row_m1    = col_entry[ENTRY_W-1:RGB_W];
    assign row_m2    = col_entry[RGB_W-1:0];

    assign o_s1_adv = !r_out_v || !i_out_stall;
    assign step     = i_s1_valid && o_s1_adv;

    assign o_ram_we    = step;
    assign o_ram_waddr = i_s1_col;
    assign o_ram_wdata = {i_s1_pixel, row_m1};

    assign is_edge = i_s1_flags.interior &&
                     ((r_w0_mid != r_w0_top) || (r_w0_mid != r_w0_bot) ||
                      (r_w0_mid != r_w1_mid) || (r_w0_mid != row_m1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_ram_re) begin
                r_fwd <= o_ram_we && (o_ram_waddr == i_ram_raddr);
            end
            if (o_s1_adv) begin
                r_out_v <= i_s1_valid && i_s1_flags.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ram_re) begin
            r_fwd_data <= o_ram_wdata;
        end
        if (step) begin
            r_w0_top <= row_m2;
            r_w0_mid <= row_m1;
            r_w0_bot <= i_s1_pixel;
            r_w1_mid <= r_w0_mid;
        end
        if (step && i_s1_flags.emit) begin
            r_out_data.is_edge <= is_edge;
            r_out_data.last    <= i_s1_flags.last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;

endmodule

[sv/color_border_edge_map_unit.sv]
// Color border edge map: marks interior pixels whose color differs from any of their
// four neighbors; two prior rows live in one line store RAM, one entry a column.
// A result goes through the stage register, then the output register, after the beat
// that completes its window, which arrives one row plus one column after the pixel.
// Throughput: one beat per clock unless output stalls; one read-modify-write per beat.
// Reset clears counters and loads the 640 by 480 geometry; line store not cleared.
module color_border_edge_map_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  cbem_pkg::t_cfg_reg              i_cfg_index,
    input  logic [cbem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cbem_pkg::t_in_beat              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cbem_pkg::t_out_beat             o_out_data
);
    import cbem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          s1_valid;
    logic          s1_adv;
    t_pixel        s1_pixel;
    logic [CW-1:0] s1_col;
    t_item_flags   s1_flags;
    logic          ram_re;
    logic [CW-1:0] ram_raddr;
    t_entry        ram_rdata;
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    t_entry        ram_wdata;

    assign o_cfg_ready = 1'b1;

    cbem_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_s1_adv    (s1_adv),
        .o_s1_valid  (s1_valid),
        .o_s1_pixel  (s1_pixel),
        .o_s1_col    (s1_col),
        .o_s1_flags  (s1_flags),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    cbem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cbem_edge #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1_pixel  (s1_pixel),
        .i_s1_col    (s1_col),
        .i_s1_flags  (s1_flags),
        .o_s1_adv    (s1_adv),
        .i_ram_re    (ram_re),
        .i_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_read_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> s1_valid)
        else $error("line store read without a stage beat");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !s1_adv) |=> s1_valid)
        else $error("stalled stage beat lost");

    a_last_is_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> !o_out_data.is_edge)
        else $error("frame corner marked as edge");

    a_write_backs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (s1_valid && s1_adv))
        else $error("line store write without an advancing beat");

endmodule
